// ===== hdl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the chunked slot allocator: command and
// status codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package csa_pkg;

    // field widths of the item and register interface
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int TOTAL_W    = 11;

    // commands
    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_CHUNK = 1'b1;

    // register reset values
    localparam logic [4:0] CHUNK_LIMIT_RST    = 5'd16;
    localparam logic [6:0] ROWS_PER_CHUNK_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOROOM  = 2'd2,
        ST_BADSLOT = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input item
        logic exec;      // commit the decision, load the result unless a move follows
        logic move;      // write the moved entity and load the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_move; // current remove relocates the chunk's last entity
    } t_dp_stat;

endpackage

// ===== hdl/csa_ctrl.sv =====
// ----------------------------------------------------------------------------
// csa_ctrl
// Sequencer of the allocator: takes one item, steps it through decision and
// optional entity move, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module csa_ctrl
    import csa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MOVE = 3'b100
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_out_free;
    logic    w_load;
    t_dp_cmd w_cmd;

    // result register can take a new transfer this cycle
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    w_cmd.exec = 1'b1;
                    n_state    = i_stat.need_move ? S_MOVE : S_IDLE;
                end
            end
            S_MOVE: begin
                if (w_out_free) begin
                    w_cmd.move = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_load      = (w_cmd.exec && !i_stat.need_move) || w_cmd.move;
    assign n_out_valid = w_load || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

endmodule

// ===== hdl/csa_datapath.sv =====
// ----------------------------------------------------------------------------
// csa_datapath
// Chunk bookkeeping, first-fit search, entity table and result register of
// the allocator. Acts on the commands of the sequencer.
// ----------------------------------------------------------------------------
module csa_datapath
    import csa_pkg::*;
#(
    parameter int MAX_CHUNKS = 16,
    parameter int MAX_ROWS   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_command,
    input  logic [31:0]           i_entity_index,
    input  logic [31:0]           i_entity_generation,
    input  logic [3:0]            i_chunk_index,
    input  logic [5:0]            i_row,
    output logic [1:0]            o_status,
    output logic [3:0]            o_slot_chunk,
    output logic [5:0]            o_slot_row,
    output logic                  o_moved_valid,
    output logic [31:0]           o_moved_index,
    output logic [31:0]           o_moved_generation,
    output logic [TOTAL_W-1:0]    o_total_entities
);

    localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int OW    = $clog2(MAX_CHUNKS + 1);
    localparam int FW    = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_CHUNKS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // registers
    logic [4:0]         r_chunk_limit;
    logic [6:0]         r_rows_per_chunk;
    logic [OW-1:0]      r_open;
    logic [FW-1:0]      r_fill [MAX_CHUNKS];
    logic [FW-1:0]      r_cap  [MAX_CHUNKS];
    logic [TOTAL_W-1:0] r_total;

    logic               r_cmd;
    logic [31:0]        r_ent_idx;
    logic [31:0]        r_ent_gen;
    logic [3:0]         r_rc;
    logic [5:0]         r_rr;

    logic [63:0]        r_mem [DEPTH];
    logic [63:0]        r_rd_data;

    t_status            r_status;
    logic [3:0]         r_slot_chunk;
    logic [5:0]         r_slot_row;
    logic               r_moved_valid;
    logic [31:0]        r_moved_index;
    logic [31:0]        r_moved_gen;
    logic [TOTAL_W-1:0] r_total_out;

    // decision logic
    logic               w_fit;
    logic [CW-1:0]      w_fit_idx;
    logic [15:0]        w_rc_wide;
    logic [CW-1:0]      w_rc_idx;
    logic [FW-1:0]      w_rc_fill;
    logic               w_slot_ok;
    logic [FW-1:0]      w_last;
    logic [15:0]        w_rows_wide;
    logic [FW-1:0]      w_eff_rows;
    logic [15:0]        w_open_wide;
    logic               w_room_new;
    t_status            w_status;
    logic               w_alloc_ok;
    logic               w_remove_ok;
    logic               w_open_new;
    logic               w_need_move;
    logic [CW-1:0]      w_sc;
    logic [FW-1:0]      w_sr;
    logic [TOTAL_W-1:0] w_total_next;
    logic [AW-1:0]      w_alloc_addr;
    logic [AW-1:0]      w_move_addr;
    logic [AW-1:0]      w_rd_addr;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_wa;
    logic [63:0]        w_mem_wd;
    logic               w_mem_re;

    // first open chunk with a free row
    always_comb begin
        w_fit     = 1'b0;
        w_fit_idx = '0;
        for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
            if ((16'(i) < 16'(r_open)) && (r_fill[i] < r_cap[i])) begin
                w_fit     = 1'b1;
                w_fit_idx = CW'(i);
            end
        end
    end

    assign w_rc_wide   = 16'(r_rc);
    assign w_rc_idx    = w_rc_wide[CW-1:0];
    assign w_rc_fill   = r_fill[w_rc_idx];
    assign w_slot_ok   = (w_rc_wide < 16'(r_open)) && (16'(r_rr) < 16'(w_rc_fill));
    assign w_last      = w_rc_fill - 1'b1;

    assign w_rows_wide = (16'(r_rows_per_chunk) > 16'(MAX_ROWS)) ? 16'(MAX_ROWS)
                                                               : 16'(r_rows_per_chunk);
    assign w_eff_rows  = w_rows_wide[FW-1:0];
    assign w_open_wide = 16'(r_open);
    assign w_room_new  = (w_open_wide < 16'(r_chunk_limit)) &&
                         (w_open_wide < 16'(MAX_CHUNKS)) && (w_eff_rows != '0);

    always_comb begin
        w_status    = ST_OK;
        w_alloc_ok  = 1'b0;
        w_remove_ok = 1'b0;
        w_open_new  = 1'b0;
        w_sc        = '0;
        w_sr        = '0;
        if (r_cmd == CMD_ALLOC) begin
            if (r_ent_gen == 32'd0) begin
                w_status = ST_INVALID;
            end else if (w_fit) begin
                w_alloc_ok = 1'b1;
                w_sc       = w_fit_idx;
                w_sr       = r_fill[w_fit_idx];
            end else if (w_room_new) begin
                w_alloc_ok = 1'b1;
                w_open_new = 1'b1;
                w_sc       = w_open_wide[CW-1:0];
            end else begin
                w_status = ST_NOROOM;
            end
        end else begin
            if (w_slot_ok) begin
                w_remove_ok = 1'b1;
            end else begin
                w_status = ST_BADSLOT;
            end
        end
    end

    assign w_need_move  = w_remove_ok && (16'(r_rr) != 16'(w_last));
    assign w_total_next = w_alloc_ok  ? r_total + 1'b1 :
                          w_remove_ok ? r_total - 1'b1 : r_total;

    // entity table addressing: chunk * rows + row
    assign w_alloc_addr = AW'(32'(w_sc) * 32'(MAX_ROWS) + 32'(w_sr));
    assign w_move_addr  = AW'(32'(w_rc_idx) * 32'(MAX_ROWS) + 32'(r_rr));
    assign w_rd_addr    = AW'(32'(w_rc_idx) * 32'(MAX_ROWS) + 32'(w_last));

    assign w_mem_we = (i_cmd.exec && w_alloc_ok) || i_cmd.move;
    assign w_mem_wa = i_cmd.move ? w_move_addr : w_alloc_addr;
    assign w_mem_wd = i_cmd.move ? r_rd_data : {r_ent_gen, r_ent_idx};
    assign w_mem_re = i_cmd.exec && w_need_move;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // chunk bookkeeping and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_limit    <= CHUNK_LIMIT_RST;
            r_rows_per_chunk <= ROWS_PER_CHUNK_RST;
            r_open           <= '0;
            r_fill           <= '{default: '0};
            r_cap            <= '{default: '0};
            r_total          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CHUNK_LIMIT:    r_chunk_limit    <= i_cfg_data[4:0];
                    REG_ROWS_PER_CHUNK: r_rows_per_chunk <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_total <= w_total_next;
                if (w_alloc_ok) begin
                    r_fill[w_sc] <= w_sr + 1'b1;
                    if (w_open_new) begin
                        r_cap[w_sc] <= w_eff_rows;
                        r_open      <= r_open + 1'b1;
                    end
                end
                if (w_remove_ok) begin
                    r_fill[w_rc_idx] <= w_last;
                end
            end
        end
    end

    // input item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd     <= i_command;
            r_ent_idx <= i_entity_index;
            r_ent_gen <= i_entity_generation;
            r_rc      <= i_chunk_index;
            r_rr      <= i_row;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !w_need_move) begin
            r_status      <= w_status;
            r_slot_chunk  <= w_alloc_ok ? 4'(w_sc) : 4'd0;
            r_slot_row    <= w_alloc_ok ? 6'(w_sr) : 6'd0;
            r_moved_valid <= 1'b0;
            r_moved_index <= '0;
            r_moved_gen   <= '0;
            r_total_out   <= w_total_next;
        end else if (i_cmd.move) begin
            r_status      <= ST_OK;
            r_slot_chunk  <= 4'd0;
            r_slot_row    <= 6'd0;
            r_moved_valid <= 1'b1;
            r_moved_index <= r_rd_data[31:0];
            r_moved_gen   <= r_rd_data[63:32];
            r_total_out   <= r_total;
        end
    end

    assign o_stat.need_move  = w_need_move;
    assign o_status           = r_status;
    assign o_slot_chunk       = r_slot_chunk;
    assign o_slot_row         = r_slot_row;
    assign o_moved_valid      = r_moved_valid;
    assign o_moved_index      = r_moved_index;
    assign o_moved_generation = r_moved_gen;
    assign o_total_entities   = r_total_out;

endmodule

// ===== hdl/chunked_slot_allocator_unit.sv =====
// Chunked slot allocator. Allocates entity identifiers into chunks first-fit
// and removes them by swap-and-pop. An allocate or a remove that moves nothing
// passes capture, then decide and commit, from transfer to result; a remove
// that moves the chunk's last entity also passes a move step, since the entity
// table is read at decide and the read data is written at move. The next item
// is taken as soon as the current one has committed, while its result waits
// in the output register; a stalled output holds the sequencer before commit.
// The entity table has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// chunked_slot_allocator_unit
// Top level: sequencer plus datapath of the slot allocator.
// ----------------------------------------------------------------------------
module chunked_slot_allocator_unit
    import csa_pkg::*;
#(
    parameter int MAX_CHUNKS = 16,
    parameter int MAX_ROWS   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_command,
    input  logic [31:0]           i_entity_index,
    input  logic [31:0]           i_entity_generation,
    input  logic [3:0]            i_chunk_index,
    input  logic [5:0]            i_row,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [3:0]            o_slot_chunk,
    output logic [5:0]            o_slot_row,
    output logic                  o_moved_valid,
    output logic [31:0]           o_moved_index,
    output logic [31:0]           o_moved_generation,
    output logic [TOTAL_W-1:0]    o_total_entities,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    csa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    csa_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_command           (i_command),
        .i_entity_index      (i_entity_index),
        .i_entity_generation (i_entity_generation),
        .i_chunk_index       (i_chunk_index),
        .i_row               (i_row),
        .o_status            (o_status),
        .o_slot_chunk        (o_slot_chunk),
        .o_slot_row          (o_slot_row),
        .o_moved_valid       (o_moved_valid),
        .o_moved_index       (o_moved_index),
        .o_moved_generation  (o_moved_generation),
        .o_total_entities    (o_total_entities)
    );

endmodule

// ===== hdl/csa_checker.sv =====
// ----------------------------------------------------------------------------
// csa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module csa_checker
    import csa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_slot_chunk,
    input logic [5:0]  o_slot_row,
    input logic        o_moved_valid,
    input logic [31:0] o_moved_index,
    input logic [31:0] o_moved_generation
);

    // one item at a time: input is stalled right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken on two consecutive cycles");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) &&
                                  $stable(o_moved_valid) && $stable(o_moved_index)))
        else $error("stalled result changed");

    // a move is only reported by a successful remove
    a_move_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_moved_valid) |-> (o_status == ST_OK && o_slot_chunk == 4'd0 &&
                                        o_slot_row == 6'd0))
        else $error("move reported with bad status or slot");

    // failed steps carry no slot and no moved entity
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_slot_chunk == 4'd0 && o_slot_row == 6'd0 &&
            !o_moved_valid && o_moved_index == 32'd0 && o_moved_generation == 32'd0))
        else $error("failed step carries slot or move data");

endmodule

bind chunked_slot_allocator_unit csa_checker u_csa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_status           (o_status),
    .o_slot_chunk       (o_slot_chunk),
    .o_slot_row         (o_slot_row),
    .o_moved_valid      (o_moved_valid),
    .o_moved_index      (o_moved_index),
    .o_moved_generation (o_moved_generation)
);
